FILE: hw/rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared constants, request/response payloads and cell types.
// ----------------------------------------------------------------------------
package lkv_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int KEY_BITS        = 16;
   localparam int VALUE_BITS      = 32;
   localparam int CAP_BITS        = 5;
   localparam int CAP_RESET       = 16;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [KEY_BITS-1:0]     lookup_key;
      logic [VALUE_BITS-1:0]   write_value;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic [VALUE_BITS-1:0]   read_value;
      logic                    evicted;
      logic [KEY_BITS-1:0]     evicted_key;
   } rsp_type;

   typedef struct packed {
      logic                    valid;
      logic [KEY_BITS-1:0]     key;
      logic [VALUE_BITS-1:0]   value;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// LRU key-value cache unit
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The store is a row of cells ordered by recency, most recent first. Every
// request is looked up in all cells at once and on a hit or a put the row
// shifts by one place in the same cycle, so one request is accepted every
// cycle and its response appears in the output register on the following
// cycle; a stalled response holds back the next request only while it waits.
// The cycle time is set by the parallel key compare and the shift control
// across the row. Writing the capacity register empties the store at once;
// capacities of zero act as one and those above MAX_ENTRIES as MAX_ENTRIES.
module lru_key_value_cache_unit
   import lkv_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_payload,
   input  logic                csr_we,
   input  logic [CAP_BITS-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CAP_RESET_EFF = (CAP_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CAP_RESET;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] eff_cap_ff, eff_cap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   entry_type        cell_entry [MAX_ENTRIES];
   entry_type        cell_prev  [MAX_ENTRIES];
   cell_ctrl_type    cell_ctrl  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] cell_match;

   entry_type             head_entry;
   logic                  accept;
   logic                  is_put;
   logic                  hit_any;
   logic                  full;
   logic [IDX_W-1:0]      found_pos;
   logic [VALUE_BITS-1:0] hit_value;
   logic [KEY_BITS-1:0]   tail_key;
   logic [CNT_W-1:0]      insert_limit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_put    = (req_payload.op == OP_PUT);
   assign full      = (count_ff >= eff_cap_ff);

   // Keys are unique among valid cells, so at most one cell matches and the
   // results can be gathered with plain OR reductions.
   always_comb begin
      found_pos = '0;
      hit_value = '0;
      tail_key  = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (cell_match[i]) begin
            found_pos = found_pos | IDX_W'(i);
            hit_value = hit_value | cell_entry[i].value;
         end
         if (cell_entry[i].valid &&
             ((i == MAX_ENTRIES - 1) || !cell_entry[(i + 1) % MAX_ENTRIES].valid)) begin
            tail_key = tail_key | cell_entry[i].key;
         end
      end
   end

   assign hit_any = |cell_match;

   // A put that misses on a full store drops the tail cell off the end of the row.
   assign insert_limit = full ? (count_ff - CNT_W'(1)) : count_ff;

   always_comb begin
      head_entry.valid = 1'b1;
      head_entry.key   = req_payload.lookup_key;
      head_entry.value = is_put ? req_payload.write_value : hit_value;
   end

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         cell_ctrl[i].clear = csr_we;
         if (!accept) begin
            cell_ctrl[i].shift = 1'b0;
         end else if (hit_any) begin
            cell_ctrl[i].shift = (IDX_W'(i) <= found_pos);
         end else begin
            cell_ctrl[i].shift = is_put && (CNT_W'(i) <= insert_limit);
         end
      end
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign cell_prev[g] = head_entry;
      end else begin : g_body
         assign cell_prev[g] = cell_entry[g-1];
      end

      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[g]),
         .prev_entry (cell_prev[g]),
         .lookup_key (req_payload.lookup_key),
         .entry      (cell_entry[g]),
         .match      (cell_match[g])
      );
   end

   always_comb begin
      rsp_in.hit         = hit_any;
      rsp_in.read_value  = (!is_put && hit_any) ? hit_value : '0;
      rsp_in.evicted     = is_put && !hit_any && full;
      rsp_in.evicted_key = (is_put && !hit_any && full) ? tail_key : '0;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      count_in = count_ff;
      if (csr_we) begin
         count_in = '0;
      end else if (accept && is_put && !hit_any && !full) begin
         count_in = count_ff + CNT_W'(1);
      end

      eff_cap_in = eff_cap_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            eff_cap_in = CNT_W'(1);
         end else if (int'(csr_wdata) > MAX_ENTRIES) begin
            eff_cap_in = CNT_W'(MAX_ENTRIES);
         end else begin
            eff_cap_in = CNT_W'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         eff_cap_ff   <= CNT_W'(CAP_RESET_EFF);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         eff_cap_ff   <= eff_cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/lkv_cell.sv
// ----------------------------------------------------------------------------
// LRU cache cell
// Holds the entry at one recency position, compares its key against the
// lookup key and takes its neighbour's entry when the row shifts.
// ----------------------------------------------------------------------------
module lkv_cell
   import lkv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  entry_type           prev_entry,
   input  logic [KEY_BITS-1:0] lookup_key,
   output entry_type           entry,
   output logic                match
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.clear) begin
         entry_in.valid = 1'b0;
      end else if (ctrl.shift) begin
         entry_in = prev_entry;
      end
   end

   // Only the valid flag is reset; key and value are read while it is set.
   always_ff @(posedge clock) begin
      entry_ff.key   <= entry_in.key;
      entry_ff.value <= entry_in.value;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry = entry_ff;
   assign match = entry_ff.valid && (entry_ff.key == lookup_key);

endmodule

FILE: hw/rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// LRU key-value cache checker
// Port-level assertions on the cache unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module lkv_checker
   import lkv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // A stalled response stays on the port.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every accepted request produces a response on the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // An eviction is only reported on a miss.
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.evicted |-> !rsp_payload.hit)
      else $error("eviction reported on a hit");

   // A read value is only returned on a hit.
   a_read_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.read_value != '0) |-> rsp_payload.hit)
      else $error("read value returned without a hit");

   // An evicted key is only shown with the evicted flag.
   a_key_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.evicted_key != '0) |-> rsp_payload.evicted)
      else $error("evicted key shown without eviction");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
